// ----- rtl/core/bmp565_pkg.sv -----
// Shared constants for the BMP to RGB565 pixel core: header layout,
// result kinds and configuration register indexes. No dependencies.
`default_nettype none

package bmp565_pkg;

  localparam int unsigned CFG_W = 8;

  localparam logic [1:0] CFG_DISPLAY_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_X       = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Y       = 2'd3;

  localparam logic [7:0] DISPLAY_WIDTH_RST  = 8'd128;
  localparam logic [7:0] DISPLAY_HEIGHT_RST = 8'd128;

  localparam logic [1:0] KIND_PIXEL     = 2'd0;
  localparam logic [1:0] KIND_BAD_SIG   = 2'd1;
  localparam logic [1:0] KIND_BAD_PLANE = 2'd2;
  localparam logic [1:0] KIND_BAD_FMT   = 2'd3;

  localparam logic [15:0] SIGNATURE = 16'h4D42;
  localparam logic [15:0] BPP_16    = 16'd16;
  localparam logic [15:0] BPP_24    = 16'd24;
  localparam logic [15:0] PLANES_1  = 16'd1;

  // last byte position of each header field
  localparam logic [31:0] POS_SIG_END     = 32'd1;
  localparam logic [31:0] POS_OFFSET_END  = 32'd13;
  localparam logic [31:0] POS_WIDTH_END   = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END  = 32'd25;
  localparam logic [31:0] POS_PLANES_END  = 32'd27;
  localparam logic [31:0] POS_DEPTH_END   = 32'd29;
  localparam logic [31:0] POS_COMP_END    = 32'd33;
  localparam logic [31:0] HEADER_END      = 32'd34;

endpackage

`default_nettype wire

// ----- rtl/core/bmp_stream_to_rgb565_pixels_core.sv -----
// BMP byte stream to RGB565 pixel core: header parser, row walker and output register.
// Depends on bmp565_pkg.
//
// Usage:
//  - in_*: one BMP file byte per transaction, in file order; in_file_start marks
//    byte 0 of a file and restarts the parser.
//  - out_*: at most one result per input byte: a pixel with display coordinates
//    or one header error (kind 1..3) after which bytes are ignored until the
//    next file start.
//  - cfg_*: write-only display size and origin, written while the core is idle.
// Output: a result is registered and shows on out_* in the cycle after its last byte.
// Throughput: one byte per cycle while in_stall is low; every byte is handled by one pass of logic
// between the parser state registers and the output register.
// Stall: the output register holds while out_stall is high; in_stall is raised
// only while a result is held and stalled, so a byte is taken in the same cycle
// the waiting result leaves.
// Reset (rst_n low, synchronous): parser back to header phase, output empty,
// display 128x128 at origin (0,0).
`default_nettype none

module bmp_stream_to_rgb565_pixels_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_data_byte,
  input  wire logic                          in_file_start,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_result_kind,
  output logic [7:0]                         out_pixel_x,
  output logic [7:0]                         out_pixel_y,
  output logic [15:0]                        out_pixel_color,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [bmp565_pkg::CFG_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_IDLE} phase_t;

  typedef struct packed {
    logic [31:0] pos;
    phase_t      phase;
    logic [31:0] shift;
    logic [31:0] offset;
    logic [31:0] width;
    logic        is24;
    logic        bottom_up;
    logic [31:0] rows_left;
    logic [31:0] img_row;
    logic [33:0] bir;
    logic [31:0] col;
    logic [15:0] partial;
    logic [1:0]  idx;
  } par_t;

  localparam par_t PAR_RESET = '{
    pos: 32'd0, phase: PH_HEADER, shift: 32'd0, offset: 32'd0, width: 32'd0,
    is24: 1'b0, bottom_up: 1'b1, rows_left: 32'd0, img_row: 32'd0,
    bir: 34'd0, col: 32'd0, partial: 16'd0, idx: 2'd0};

  par_t        par_r, par_nxt, eff;
  logic [7:0]  disp_w_r, disp_h_r, org_x_r, org_y_r;
  logic [33:0] row_bytes_r, stride_r;

  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  px_r, px_nxt, py_r, py_nxt;
  logic [15:0] color_r, color_nxt;
  logic        emit;
  logic        in_fire;
  logic        visible;

  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign visible   = (org_x_r < disp_w_r) && (org_y_r < disp_h_r);
  assign eff       = in_file_start ? PAR_RESET : par_r;

  assign out_valid       = out_valid_r;
  assign out_result_kind = kind_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = color_r;

  always_comb begin
    logic        fail;
    logic [1:0]  fail_kind;
    phase_t      ph;
    logic [33:0] bir_inc;
    logic [7:0]  vis_w, vis_h;
    logic        last_byte;

    par_nxt   = eff;
    emit      = 1'b0;
    kind_nxt  = bmp565_pkg::KIND_PIXEL;
    px_nxt    = 8'd0;
    py_nxt    = 8'd0;
    color_nxt = 16'd0;
    fail      = 1'b0;
    fail_kind = bmp565_pkg::KIND_BAD_SIG;
    ph        = eff.phase;
    bir_inc   = eff.bir + 34'd1;
    vis_w     = disp_w_r - org_x_r;
    vis_h     = disp_h_r - org_y_r;
    last_byte = eff.is24 ? (eff.idx == 2'd2) : (eff.idx == 2'd1);

    if (eff.pos != 32'hFFFF_FFFF) begin
      par_nxt.pos = eff.pos + 32'd1;
    end

    if (eff.phase == PH_HEADER && eff.pos < bmp565_pkg::HEADER_END) begin
      par_nxt.shift = {in_data_byte, eff.shift[31:8]};
      case (eff.pos)
        bmp565_pkg::POS_SIG_END: begin
          if (par_nxt.shift[31:16] != bmp565_pkg::SIGNATURE) begin
            fail      = 1'b1;
            fail_kind = bmp565_pkg::KIND_BAD_SIG;
          end
        end
        bmp565_pkg::POS_OFFSET_END: par_nxt.offset = par_nxt.shift;
        bmp565_pkg::POS_WIDTH_END:  par_nxt.width  = par_nxt.shift;
        bmp565_pkg::POS_HEIGHT_END: begin
          if (par_nxt.shift[31]) begin
            par_nxt.rows_left = 32'd0 - par_nxt.shift;
            par_nxt.bottom_up = 1'b0;
            par_nxt.img_row   = 32'd0;
          end else begin
            par_nxt.rows_left = par_nxt.shift;
            par_nxt.bottom_up = 1'b1;
            par_nxt.img_row   = par_nxt.shift - 32'd1;
          end
        end
        bmp565_pkg::POS_PLANES_END: begin
          if (par_nxt.shift[31:16] != bmp565_pkg::PLANES_1) begin
            fail      = 1'b1;
            fail_kind = bmp565_pkg::KIND_BAD_PLANE;
          end
        end
        bmp565_pkg::POS_DEPTH_END: begin
          par_nxt.is24 = (par_nxt.shift[31:16] == bmp565_pkg::BPP_24);
          if (par_nxt.shift[31:16] != bmp565_pkg::BPP_16 &&
              par_nxt.shift[31:16] != bmp565_pkg::BPP_24) begin
            fail      = 1'b1;
            fail_kind = bmp565_pkg::KIND_BAD_FMT;
          end
        end
        bmp565_pkg::POS_COMP_END: begin
          if (par_nxt.shift != 32'd0) begin
            fail      = 1'b1;
            fail_kind = bmp565_pkg::KIND_BAD_FMT;
          end else begin
            par_nxt.phase = PH_SKIP;
          end
        end
        default: ;
      endcase
      if (fail) begin
        par_nxt.phase = PH_IDLE;
        emit          = visible;
        kind_nxt      = fail_kind;
      end
    end else begin
      if (ph == PH_SKIP && eff.pos >= eff.offset) begin
        ph = PH_PIXELS;
      end
      par_nxt.phase = ph;
      if (ph == PH_PIXELS) begin
        if (eff.rows_left == 32'd0 || eff.width == 32'd0) begin
          par_nxt.phase = PH_IDLE;
        end else begin
          if (eff.bir < row_bytes_r) begin
            if (!last_byte) begin
              if (eff.idx[0]) begin
                par_nxt.partial = eff.partial | {in_data_byte, 8'd0};
              end else begin
                par_nxt.partial = eff.partial | {8'd0, in_data_byte};
              end
              par_nxt.idx = eff.idx + 2'd1;
            end else begin
              if (eff.is24) begin
                color_nxt = {in_data_byte[7:3], eff.partial[15:10], eff.partial[7:3]};
              end else begin
                color_nxt = {in_data_byte, eff.partial[7:0]};
              end
              px_nxt = org_x_r + eff.col[7:0];
              py_nxt = org_y_r + eff.img_row[7:0];
              emit   = visible && (eff.col < {24'd0, vis_w}) &&
                       (eff.img_row < {24'd0, vis_h});
              par_nxt.idx     = 2'd0;
              par_nxt.partial = 16'd0;
              par_nxt.col     = eff.col + 32'd1;
            end
          end
          if (bir_inc >= stride_r) begin
            par_nxt.bir       = 34'd0;
            par_nxt.col       = 32'd0;
            par_nxt.rows_left = eff.rows_left - 32'd1;
            par_nxt.img_row   = eff.bottom_up ? eff.img_row - 32'd1 : eff.img_row + 32'd1;
            if (eff.rows_left == 32'd1) begin
              par_nxt.phase = PH_IDLE;
            end
          end else begin
            par_nxt.bir = bir_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_r       <= PAR_RESET;
      out_valid_r <= 1'b0;
      disp_w_r    <= bmp565_pkg::DISPLAY_WIDTH_RST;
      disp_h_r    <= bmp565_pkg::DISPLAY_HEIGHT_RST;
      org_x_r     <= 8'd0;
      org_y_r     <= 8'd0;
      row_bytes_r <= 34'd0;
      stride_r    <= 34'd0;
    end else begin
      // row geometry is registered from the parsed width and depth: row_bytes_r, then stride_r
      row_bytes_r <= par_r.is24 ? ({2'd0, par_r.width} + {1'b0, par_r.width, 1'b0})
                                : {1'b0, par_r.width, 1'b0};
      stride_r    <= (row_bytes_r + 34'd3) & ~34'd3;
      if (in_fire) begin
        par_r       <= par_nxt;
        out_valid_r <= emit;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          bmp565_pkg::CFG_DISPLAY_WIDTH:  disp_w_r <= cfg_data;
          bmp565_pkg::CFG_DISPLAY_HEIGHT: disp_h_r <= cfg_data;
          bmp565_pkg::CFG_ORIGIN_X:       org_x_r  <= cfg_data;
          bmp565_pkg::CFG_ORIGIN_Y:       org_y_r  <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      kind_r  <= kind_nxt;
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      color_r <= color_nxt;
    end
  end

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_file_start && par_r.phase == PH_IDLE) |-> !emit)
    else $error("result produced while parser idle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind != bmp565_pkg::KIND_PIXEL) |->
      (out_pixel_x == 8'd0 && out_pixel_y == 8'd0 && out_pixel_color == 16'd0))
    else $error("error result with nonzero payload");

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit && kind_nxt != bmp565_pkg::KIND_PIXEL) |=> par_r.phase == PH_IDLE)
    else $error("parser not idle after header error");

endmodule

`default_nettype wire

// ----- test/tb_bmp_stream_to_rgb565_pixels_core.sv -----
// Testbench for bmp_stream_to_rgb565_pixels_core: streams whole and broken BMP files,
// predicts RGB565 pixels and header errors per byte and checks every output transaction.
// Depends on bmp565_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_bmp_stream_to_rgb565_pixels_core;

  typedef enum logic [2:0] {PH_HEADER, PH_SKIP, PH_PIXELS, PH_IDLE} parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } file_byte_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] color;
  } pix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_file_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [15:0] out_pixel_color;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [bmp565_pkg::CFG_W-1:0] cfg_data = '0;

  bmp_stream_to_rgb565_pixels_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_file_start   (in_file_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_kind (out_result_kind),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // display window as currently programmed
  logic [7:0] cfg_dw, cfg_dh, cfg_ox, cfg_oy;

  // parser state of the predictor
  parse_phase_t ph;
  logic [31:0]  pos_q, shreg, offset_q, width_q, height_q, rows_done;
  logic [15:0]  bpp_q, partial_q;
  logic         bottom_up;
  logic [63:0]  in_row;
  logic [1:0]   pb_idx;

  file_byte_t  pend_bytes[$];
  pix_result_t expected_pixels[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int unsigned queued = 0, n_in = 0, n_out = 0, n_files = 0;
  int fails = 0;

  logic hold_go = 1'b0;
  logic hold_done = 1'b0;
  wire  rx_hold = hold_go & ~hold_done;

  file_byte_t  drv_byte;
  pix_result_t drv_res;
  pix_result_t mon_want;

  function automatic void clear_parser();
    pos_q = '0;
    ph = PH_HEADER;
    shreg = '0;
    offset_q = '0;
    width_q = '0;
    height_q = '0;
    bpp_q = '0;
    bottom_up = 1'b1;
    rows_done = '0;
    in_row = '0;
    partial_q = '0;
    pb_idx = '0;
  endfunction

  function automatic bit origin_on();
    return (cfg_ox < cfg_dw) && (cfg_oy < cfg_dh);
  endfunction

  function automatic bit report_error(input logic [1:0] kind, output pix_result_t r);
    r = '0;
    ph = PH_IDLE;
    if (!origin_on()) return 1'b0;
    r.kind = kind;
    return 1'b1;
  endfunction

  function automatic bit header_step(input logic [31:0] at, input logic [7:0] b,
                                     output pix_result_t r);
    r = '0;
    shreg = {b, shreg[31:8]};
    case (at)
      bmp565_pkg::POS_SIG_END: begin
        if (shreg[31:16] != bmp565_pkg::SIGNATURE)
          return report_error(bmp565_pkg::KIND_BAD_SIG, r);
      end
      bmp565_pkg::POS_OFFSET_END: offset_q = shreg;
      bmp565_pkg::POS_WIDTH_END:  width_q = shreg;
      bmp565_pkg::POS_HEIGHT_END: begin
        if (shreg[31]) begin
          height_q = 32'd0 - shreg;
          bottom_up = 1'b0;
        end else begin
          height_q = shreg;
          bottom_up = 1'b1;
        end
      end
      bmp565_pkg::POS_PLANES_END: begin
        if (shreg[31:16] != bmp565_pkg::PLANES_1)
          return report_error(bmp565_pkg::KIND_BAD_PLANE, r);
      end
      bmp565_pkg::POS_DEPTH_END: begin
        bpp_q = shreg[31:16];
        if (bpp_q != bmp565_pkg::BPP_16 && bpp_q != bmp565_pkg::BPP_24)
          return report_error(bmp565_pkg::KIND_BAD_FMT, r);
      end
      bmp565_pkg::POS_COMP_END: begin
        if (shreg != 32'd0) return report_error(bmp565_pkg::KIND_BAD_FMT, r);
        ph = PH_SKIP;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit pixel_step(input logic [7:0] b, output pix_result_t r);
    logic [63:0] nbytes, row_bytes, stride, col, img_row;
    logic [15:0] color;
    bit hit;
    hit = 1'b0;
    r = '0;
    nbytes = (bpp_q == bmp565_pkg::BPP_24) ? 64'd3 : 64'd2;
    row_bytes = {32'd0, width_q} * nbytes;
    stride = (row_bytes + 64'd3) & ~64'd3;
    if (rows_done >= height_q || row_bytes == 64'd0) begin
      ph = PH_IDLE;
      return 1'b0;
    end
    if (in_row < row_bytes) begin
      if ({62'd0, pb_idx} + 64'd1 < nbytes) begin
        partial_q = partial_q | ({8'd0, b} << (pb_idx[0] ? 8 : 0));
        pb_idx = pb_idx + 2'd1;
      end else begin
        col = in_row / nbytes;
        img_row = bottom_up ? {32'd0, height_q} - 64'd1 - {32'd0, rows_done}
                            : {32'd0, rows_done};
        color = (nbytes == 64'd2) ? (partial_q | {b, 8'd0})
                                  : {b[7:3], partial_q[15:10], partial_q[7:3]};
        if (origin_on() && col < {56'd0, cfg_dw - cfg_ox}
            && img_row < {56'd0, cfg_dh - cfg_oy}) begin
          r.kind = bmp565_pkg::KIND_PIXEL;
          r.x = cfg_ox + col[7:0];
          r.y = cfg_oy + img_row[7:0];
          r.color = color;
          hit = 1'b1;
        end
        pb_idx = '0;
        partial_q = '0;
      end
    end
    in_row = in_row + 64'd1;
    if (in_row >= stride) begin
      in_row = '0;
      rows_done = rows_done + 32'd1;
      if (rows_done >= height_q) ph = PH_IDLE;
    end
    return hit;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                     output pix_result_t r);
    logic [31:0] at;
    bit hit;
    hit = 1'b0;
    r = '0;
    if (start) clear_parser();
    at = pos_q;
    if (ph == PH_HEADER && at < bmp565_pkg::HEADER_END) begin
      hit = header_step(at, b, r);
    end else begin
      if (ph == PH_SKIP && at >= offset_q) ph = PH_PIXELS;
      if (ph == PH_PIXELS) hit = pixel_step(b, r);
    end
    if (pos_q != 32'hFFFF_FFFF) pos_q = pos_q + 32'd1;
    return hit;
  endfunction

  // driver: predicts on each accepted transaction, then offers the next byte
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        n_in++;
        if (decode_byte(in_data_byte, in_file_start, drv_res)) expected_pixels.push_back(drv_res);
      end
      if (!in_valid || !in_stall) begin
        if (pend_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          drv_byte = pend_bytes.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= drv_byte.data;
          in_file_start <= drv_byte.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected result: kind %0d x %0d y %0d color 0x%04h",
                 out_result_kind, out_pixel_x, out_pixel_y, out_pixel_color);
          fails++;
        end else begin
          mon_want = expected_pixels.pop_front();
          if (out_result_kind !== mon_want.kind) begin
            $error("result_kind: expected %0d, got %0d", mon_want.kind, out_result_kind);
            fails++;
          end
          if (out_pixel_x !== mon_want.x) begin
            $error("pixel_x: expected %0d, got %0d", mon_want.x, out_pixel_x);
            fails++;
          end
          if (out_pixel_y !== mon_want.y) begin
            $error("pixel_y: expected %0d, got %0d", mon_want.y, out_pixel_y);
            fails++;
          end
          if (out_pixel_color !== mon_want.color) begin
            $error("pixel_color: expected 0x%04h, got 0x%04h", mon_want.color, out_pixel_color);
            fails++;
          end
        end
      end
      out_stall <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // long receiver hold-off, counted here once requested
  initial begin
    wait (hold_go);
    repeat (400) @(posedge clk);
    hold_done <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("bmp_stream_to_rgb565_pixels_core: mismatch");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    pend_bytes.push_back('{data: b, start: start});
    queued++;
  endtask

  task automatic push_le(input logic [31:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) push_byte(v[8*i +: 8], 1'b0);
  endtask

  task automatic send_file(input logic [15:0] sig, input logic [31:0] off, w, h,
                           input logic [15:0] planes, bpp, input logic [31:0] comp,
                           input int body, input int solid);
    n_files++;
    push_byte(sig[7:0], 1'b1);
    push_byte(sig[15:8], 1'b0);
    push_le($urandom, 4);
    push_le($urandom, 4);
    push_le(off, 4);
    push_le(32'd40, 4);
    push_le(w, 4);
    push_le(h, 4);
    push_le({16'd0, planes}, 2);
    push_le({16'd0, bpp}, 2);
    push_le(comp, 4);
    for (int i = 0; i < body; i++)
      push_byte((solid < 0) ? 8'($urandom_range(0, 255)) : 8'(solid), 1'b0);
  endtask

  task automatic rand_file();
    int sel, nb, hmag, body;
    logic [15:0] sig, planes, bpp;
    logic [31:0] off, w, h, comp;
    sel = $urandom_range(0, 99);
    sig = bmp565_pkg::SIGNATURE;
    planes = bmp565_pkg::PLANES_1;
    bpp = $urandom_range(0, 1) ? bmp565_pkg::BPP_24 : bmp565_pkg::BPP_16;
    comp = 32'd0;
    w = $urandom_range(0, 7);
    hmag = $urandom_range(0, 5);
    h = $urandom_range(0, 1) ? 32'd0 - hmag : hmag;
    off = $urandom_range(0, 1) ? $urandom_range(0, 33) : $urandom_range(34, 60);
    if (sel < 5) begin
      // noise, sometimes with a stray file start
      repeat ($urandom_range(1, 20))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      return;
    end
    if (sel < 9) sig = sig ^ (16'd1 << $urandom_range(0, 15));
    else if (sel < 12) planes = 16'($urandom_range(0, 65535));
    else if (sel < 15) bpp = 16'($urandom_range(0, 65535));
    else if (sel < 18) comp = $urandom | (32'd1 << $urandom_range(0, 31));
    nb = (bpp == bmp565_pkg::BPP_24) ? 3 : 2;
    body = ((off > 34) ? off - 34 : 0) + (((w * nb + 3) / 4) * 4) * hmag
           + $urandom_range(0, 3);
    if (sel < 18) body = $urandom_range(0, 8);
    else if (sel < 26) body = $urandom_range(0, body);
    send_file(sig, off, w, h, planes, bpp, comp, body, -1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      bmp565_pkg::CFG_DISPLAY_WIDTH:  cfg_dw = v;
      bmp565_pkg::CFG_DISPLAY_HEIGHT: cfg_dh = v;
      bmp565_pkg::CFG_ORIGIN_X:       cfg_ox = v;
      bmp565_pkg::CFG_ORIGIN_Y:       cfg_oy = v;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pend_bytes.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] dw, dh, ox, oy, input int tx, rx, budget,
                           input bit hold);
    int unsigned mark;
    write_reg(bmp565_pkg::CFG_DISPLAY_WIDTH, dw);
    write_reg(bmp565_pkg::CFG_DISPLAY_HEIGHT, dh);
    write_reg(bmp565_pkg::CFG_ORIGIN_X, ox);
    write_reg(bmp565_pkg::CFG_ORIGIN_Y, oy);
    @(negedge clk);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    if (hold) hold_go = 1'b1;
    mark = queued;
    while (queued - mark < budget) rand_file();
    wait_idle();
  endtask

  initial begin
    cfg_dw = bmp565_pkg::DISPLAY_WIDTH_RST;
    cfg_dh = bmp565_pkg::DISPLAY_HEIGHT_RST;
    cfg_ox = 8'd0;
    cfg_oy = 8'd0;
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed files at the reset window
    send_file(~bmp565_pkg::SIGNATURE, 32'd54, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_16, 32'd0, 6, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd54, 32'd2, 32'd2, 16'd0,
              bmp565_pkg::BPP_16, 32'd0, 6, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd54, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
              16'd8, 32'd1, 4, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd54, 32'd2, 32'd2, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_24, 32'd3, 4, -1);
    // top-down 16-bit with skipped gap and trailing bytes
    send_file(bmp565_pkg::SIGNATURE, 32'd40, 32'd2, -32'sd2, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_16, 32'd0, 18, 8'hFF);
    // bottom-up 24-bit with row padding, offset inside the header
    send_file(bmp565_pkg::SIGNATURE, 32'd10, 32'd3, 32'd2, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_24, 32'd0, 26, 8'h00);
    send_file(bmp565_pkg::SIGNATURE, 32'd34, 32'd2, 32'd1, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_24, 32'd0, 8, 8'hFF);
    send_file(bmp565_pkg::SIGNATURE, 32'd34, 32'd5, 32'd3, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_16, 32'd0, 30, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd34, 32'd0, 32'd3, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_16, 32'd0, 8, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd34, 32'd2, 32'd0, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_24, 32'd0, 8, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd34, 32'd1, 32'h8000_0000, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_16, 32'd0, 16, -1);
    send_file(bmp565_pkg::SIGNATURE, 32'd34, 32'hFFFF_FFFF, 32'd1, bmp565_pkg::PLANES_1,
              bmp565_pkg::BPP_24, 32'd0, 15, -1);
    wait_idle();

    run_phase(8'd255, 8'd255, 8'd0,   8'd0,   0,  0,  150, 1'b1);
    run_phase(8'd4,   8'd3,   8'd1,   8'd2,   69, 0,  140, 1'b0);
    run_phase(8'd1,   8'd1,   8'd0,   8'd0,   0,  69, 140, 1'b0);
    run_phase(8'd200, 8'd100, 8'd255, 8'd255, 35, 35, 110, 1'b0);
    run_phase(8'd255, 8'd255, 8'd251, 8'd252, 35, 35, 140, 1'b0);
    run_phase(8'd16,  8'd255, 8'd2,   8'd254, 69, 69, 130, 1'b0);

    $display("%0d bytes in %0d files accepted, %0d results checked", n_in, n_files, n_out);
    $display("covered: header errors, 16/24-bit, both row orders, cropping, off-screen origin");
    if (fails == 0) begin
      $display("bmp_stream_to_rgb565_pixels_core: match");
    end else begin
      $display("bmp_stream_to_rgb565_pixels_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bmp565_pkg.sv
rtl/core/bmp_stream_to_rgb565_pixels_core.sv
test/tb_bmp_stream_to_rgb565_pixels_core.sv
